// ===== design/sample_distribution_summary_unit_macros.svh =====
// Assertion macros shared by the statistics unit.
// Each macro samples on clk and is held off while arst_n is low.
`ifndef SAMPLE_DISTRIBUTION_SUMMARY_UNIT_MACROS_SVH
`define SAMPLE_DISTRIBUTION_SUMMARY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SDSU_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("sdsu assertion failed");
`define SDSU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdsu assertion failed");
`else
`define SDSU_ASSERT(label, cond)
`define SDSU_ASSERT_IMP(label, ante, cons)
`endif
`endif

// ===== design/sdsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sdsu_pkg;

	typedef struct packed {
		logic [31:0] sample;
		logic        has_sample;
		logic        last;
	} load_t;

	typedef struct packed {
		logic [3:0]  statistic;
		logic [63:0] value;
		logic        overflow;
		logic        last_result;
	} stat_t;

	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		JOB_MEAN,
		JOB_LOW1,
		JOB_LOW01,
		JOB_VAR1,
		JOB_VAR2
	} div_job_t;

	localparam logic [3:0] STAT_COUNT  = 4'd0;
	localparam logic [3:0] STAT_MIN    = 4'd1;
	localparam logic [3:0] STAT_MAX    = 4'd2;
	localparam logic [3:0] STAT_MEAN   = 4'd3;
	localparam logic [3:0] STAT_P10    = 4'd4;
	localparam logic [3:0] STAT_LOW1   = 4'd9;
	localparam logic [3:0] STAT_LOW01  = 4'd10;
	localparam logic [3:0] STAT_VAR    = 4'd11;
	localparam logic [3:0] STAT_STDDEV = 4'd12;
	localparam int         NUM_STATS   = 13;
	localparam int         NUM_PCT     = 5;

	// Percentile points, in the order of their statistic codes.
	function automatic logic [6:0] pct_point(input logic [2:0] idx);
		logic [6:0] r;
		r = 7'd99;
		case (idx)
			3'd0: r = 7'd10;
			3'd1: r = 7'd50;
			3'd2: r = 7'd90;
			3'd3: r = 7'd95;
			default: r = 7'd99;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/sdsu_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One cell of the insertion chain: holds one sample in sorted position.
module sdsu_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sdsu_pkg::cell_ctrl_t ctrl,
	input  wire logic [31:0]         x,
	input  wire logic [31:0]         prev_val,
	input  wire logic                prev_valid,
	input  wire logic                prev_gt,
	input  wire logic [31:0]         next_val,
	output logic [31:0]              val,
	output logic                     valid,
	output logic                     gt
);
	logic take;

	assign gt   = valid && (val > x);
	assign take = gt || (!valid && prev_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (ctrl.clear) begin
			valid <= 1'b0;
		end else if (ctrl.insert && take) begin
			valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val <= next_val;
		end else if (ctrl.insert && take) begin
			val <= prev_gt ? prev_val : x;
		end
	end
endmodule
`default_nettype wire

// ===== design/sdsu_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Row of cells kept in ascending order; shifting moves every value one cell
// towards the head so the sorted contents stream out of cell zero.
module sdsu_chain #(
	parameter int CAPACITY = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sdsu_pkg::cell_ctrl_t ctrl,
	input  wire logic [31:0]         x,
	output logic [31:0]              head_val,
	output logic                     head_valid
);
	logic [31:0] vals   [CAPACITY];
	logic        valids [CAPACITY];
	logic        gts    [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] pv;
		logic        pvld;
		logic        pgt;
		logic [31:0] nv;
		if (i == 0) begin : g_first
			assign pv   = 32'd0;
			assign pvld = 1'b1;
			assign pgt  = 1'b0;
		end else begin : g_mid
			assign pv   = vals[i-1];
			assign pvld = valids[i-1];
			assign pgt  = gts[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign nv = 32'd0;
		end else begin : g_body
			assign nv = vals[i+1];
		end
		sdsu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.x         (x),
			.prev_val  (pv),
			.prev_valid(pvld),
			.prev_gt   (pgt),
			.next_val  (nv),
			.val       (vals[i]),
			.valid     (valids[i]),
			.gt        (gts[i])
		);
	end

	assign head_val   = vals[0];
	assign head_valid = valids[0];
endmodule
`default_nettype wire

// ===== design/sample_distribution_summary_unit.sv =====
// A sample takes its sorted place in the chain when it is accepted. A closing transaction
// is followed by the scan of the sorted samples, a drain state, the shift-add products,
// five divider runs and the square-root steps, then 13 results (one if empty).
// Throughput: one sample per cycle while loading; the shared serial divider sets
// the length of the statistics run. The output register then emits one per cycle while stat_ready allows.
// Reset (arst_n low, asynchronous) empties the chain and clears count, sum and flag.
`timescale 1ns / 1ps
`default_nettype none
`include "sample_distribution_summary_unit_macros.svh"
module sample_distribution_summary_unit #(
	parameter int CAPACITY = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load_valid,
	output logic                load_ready,
	input  wire sdsu_pkg::load_t load_data,
	output logic                stat_valid,
	input  wire logic           stat_ready,
	output sdsu_pkg::stat_t     stat_data
);
	// Widths follow from the capacity: count, sum of samples, and the
	// variance numerator n*sum(x^2) - S^2.
	localparam int LG  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int SW  = 32 + LG;
	localparam int DW  = 64 + 2 * LG;
	localparam int DCW = $clog2(DW + 1);
	localparam int PW  = CW + 10;

	sdsu_pkg::state_t   state_q, state_d;
	sdsu_pkg::div_job_t djob_q;
	sdsu_pkg::cell_ctrl_t cctrl;

	logic [CW-1:0]  count_q;
	logic [SW-1:0]  sum_q;
	logic           drop_q;
	logic [CW-1:0]  j_q;
	logic           mjob_q;
	logic [DCW-1:0] dcnt_q;
	logic [3:0]     eidx_q, elast_q;
	logic           stat_valid_q;
	sdsu_pkg::stat_t stat_q;

	logic [63:0]    res_q [sdsu_pkg::NUM_STATS];
	logic [SW-1:0]  t1_q, t2_q;
	logic [CW-1:0]  c1_q, c2_q;
	logic [63:0]    sq_s1;
	logic           sq_v_s1;
	logic [DW-1:0]  sumsq_q;
	logic [DW-1:0]  ma_q, prod_q, s2_q, num_q;
	logic [SW-1:0]  mb_q;
	logic [DW-1:0]  dq_q;
	logic [CW-1:0]  rem_q, dd_q;
	logic [63:0]    sv_q, sr_q, sb_q;

	logic [31:0]    head_val;
	logic           head_valid;

	// Handshake decodes.
	logic load_fire, full, insert, emit_go, emit_last;
	logic [CW-1:0] n_new;

	assign load_fire = load_valid && load_ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign insert    = load_fire && load_data.has_sample && !full;
	assign n_new     = count_q + CW'(insert);
	assign emit_go   = (state_q == sdsu_pkg::ST_EMIT) && (!stat_valid_q || stat_ready);
	assign emit_last = (eidx_q == elast_q);

	// Scan-side decodes: the head cell holds the j-th smallest sample.
	logic [PW-1:0] jw, nw, m1;
	logic [sdsu_pkg::NUM_PCT-1:0] pct_hit;
	logic in_t1, in_t2;

	always_comb begin
		logic [PW-1:0] kn;
		jw = PW'(j_q);
		nw = PW'(count_q);
		m1 = nw - jw - PW'(1);
		for (int p = 0; p < sdsu_pkg::NUM_PCT; p++) begin
			kn = PW'(sdsu_pkg::pct_point(3'(p))) * nw;
			// The nearest rank is the first position whose 100*(j+1) reaches k*n.
			pct_hit[p] = ((jw + PW'(1)) * PW'(100) >= kn) &&
				((j_q == '0) || (jw * PW'(100) < kn));
		end
		in_t1 = (m1 * PW'(100)) < nw;
		in_t2 = (m1 * PW'(1000)) < nw;
	end

	// Shared serial units: one restoring divider step and one square-root step.
	logic [CW:0]   r2, r2_sub;
	logic          div_ge;
	logic [CW-1:0] rem_n;
	logic [63:0]   sq_trial;
	logic          sq_ge;

	assign r2       = {rem_q, dq_q[DW-1]};
	assign r2_sub   = r2 - {1'b0, dd_q};
	assign div_ge   = (r2 >= {1'b0, dd_q});
	assign rem_n    = div_ge ? r2_sub[CW-1:0] : r2[CW-1:0];
	assign sq_trial = sr_q + sb_q;
	assign sq_ge    = (sv_q >= sq_trial);

	// The sorted store: a sample lands in place when it is accepted, and during the scan the
	// whole row moves one cell per cycle towards the head.
	sdsu_chain #(
		.CAPACITY(CAPACITY)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (cctrl),
		.x         (load_data.sample),
		.head_val  (head_val),
		.head_valid(head_valid)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdsu_pkg::ST_LOAD: begin
				if (load_fire && load_data.last) begin
					state_d = (n_new == '0) ? sdsu_pkg::ST_EMIT : sdsu_pkg::ST_SCAN;
				end
			end
			sdsu_pkg::ST_SCAN: begin
				if (j_q == count_q - CW'(1)) begin
					state_d = sdsu_pkg::ST_DRAIN;
				end
			end
			sdsu_pkg::ST_DRAIN: state_d = sdsu_pkg::ST_MUL;
			sdsu_pkg::ST_MUL: begin
				if (mb_q == '0 && mjob_q) begin
					state_d = sdsu_pkg::ST_DIV;
				end
			end
			sdsu_pkg::ST_DIV: begin
				if (dcnt_q == DCW'(DW) && djob_q == sdsu_pkg::JOB_VAR2) begin
					state_d = sdsu_pkg::ST_SQRT;
				end
			end
			sdsu_pkg::ST_SQRT: begin
				if (sb_q == '0) begin
					state_d = sdsu_pkg::ST_EMIT;
				end
			end
			sdsu_pkg::ST_EMIT: begin
				if (emit_go && emit_last) begin
					state_d = sdsu_pkg::ST_LOAD;
				end
			end
			default: state_d = sdsu_pkg::ST_LOAD;
		endcase
	end

	// Outputs and chain control.
	always_comb begin
		load_ready   = (state_q == sdsu_pkg::ST_LOAD);
		cctrl.insert = insert;
		cctrl.shift  = (state_q == sdsu_pkg::ST_SCAN);
		cctrl.clear  = emit_go && emit_last;
	end

	assign stat_valid = stat_valid_q;
	assign stat_data  = stat_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sdsu_pkg::ST_LOAD;
			count_q      <= '0;
			sum_q        <= '0;
			drop_q       <= 1'b0;
			j_q          <= '0;
			mjob_q       <= 1'b0;
			dcnt_q       <= '0;
			djob_q       <= sdsu_pkg::JOB_MEAN;
			eidx_q       <= '0;
			elast_q      <= '0;
			stat_valid_q <= 1'b0;
			sq_v_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			sq_v_s1 <= (state_q == sdsu_pkg::ST_SCAN);
			if (insert) begin
				count_q <= n_new;
				sum_q   <= sum_q + SW'(load_data.sample);
			end
			if (load_fire && load_data.has_sample && full) begin
				drop_q <= 1'b1;
			end
			if (load_fire && load_data.last) begin
				j_q     <= '0;
				eidx_q  <= '0;
				elast_q <= (n_new == '0) ? sdsu_pkg::STAT_COUNT : sdsu_pkg::STAT_STDDEV;
			end
			if (state_q == sdsu_pkg::ST_SCAN) begin
				j_q <= j_q + CW'(1);
			end
			if (state_q == sdsu_pkg::ST_DRAIN) begin
				mjob_q <= 1'b0;
			end
			if (state_q == sdsu_pkg::ST_MUL && mb_q == '0) begin
				mjob_q <= 1'b1;
				if (mjob_q) begin
					dcnt_q <= '0;
					djob_q <= sdsu_pkg::JOB_MEAN;
				end
			end
			if (state_q == sdsu_pkg::ST_DIV) begin
				if (dcnt_q != DCW'(DW)) begin
					dcnt_q <= dcnt_q + DCW'(1);
				end else begin
					dcnt_q <= '0;
					unique case (djob_q)
						sdsu_pkg::JOB_MEAN:  djob_q <= sdsu_pkg::JOB_LOW1;
						sdsu_pkg::JOB_LOW1:  djob_q <= sdsu_pkg::JOB_LOW01;
						sdsu_pkg::JOB_LOW01: djob_q <= sdsu_pkg::JOB_VAR1;
						sdsu_pkg::JOB_VAR1:  djob_q <= sdsu_pkg::JOB_VAR2;
						default:             djob_q <= sdsu_pkg::JOB_MEAN;
					endcase
				end
			end
			if (emit_go) begin
				stat_valid_q <= 1'b1;
				eidx_q       <= eidx_q + 4'd1;
				if (emit_last) begin
					count_q <= '0;
					sum_q   <= '0;
					drop_q  <= 1'b0;
				end
			end else if (stat_ready) begin
				stat_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (load_fire && load_data.last) begin
			res_q[sdsu_pkg::STAT_COUNT] <= 64'(n_new);
			t1_q    <= '0;
			t2_q    <= '0;
			c1_q    <= '0;
			c2_q    <= '0;
			sumsq_q <= '0;
		end
		sq_s1 <= head_val * head_val;
		if (sq_v_s1) begin
			sumsq_q <= sumsq_q + DW'(sq_s1);
		end
		if (state_q == sdsu_pkg::ST_SCAN) begin
			if (j_q == '0) begin
				res_q[sdsu_pkg::STAT_MIN] <= 64'(head_val);
			end
			if (j_q == count_q - CW'(1)) begin
				res_q[sdsu_pkg::STAT_MAX] <= 64'(head_val);
			end
			for (int p = 0; p < sdsu_pkg::NUM_PCT; p++) begin
				if (pct_hit[p]) begin
					res_q[sdsu_pkg::STAT_P10 + 4'(p)] <= 64'(head_val);
				end
			end
			if (in_t1) begin
				t1_q <= t1_q + SW'(head_val);
				c1_q <= c1_q + CW'(1);
			end
			if (in_t2) begin
				t2_q <= t2_q + SW'(head_val);
				c2_q <= c2_q + CW'(1);
			end
		end
		if (state_q == sdsu_pkg::ST_DRAIN) begin
			ma_q   <= DW'(sum_q);
			mb_q   <= sum_q;
			prod_q <= '0;
		end
		if (state_q == sdsu_pkg::ST_MUL) begin
			if (mb_q != '0) begin
				if (mb_q[0]) begin
					prod_q <= prod_q + ma_q;
				end
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end else if (!mjob_q) begin
				s2_q   <= prod_q;
				ma_q   <= sumsq_q;
				mb_q   <= SW'(count_q);
				prod_q <= '0;
			end else begin
				num_q <= prod_q - s2_q;
				dq_q  <= DW'(sum_q);
				dd_q  <= count_q;
				rem_q <= '0;
			end
		end
		if (state_q == sdsu_pkg::ST_DIV) begin
			if (dcnt_q != DCW'(DW)) begin
				rem_q <= rem_n;
				dq_q  <= {dq_q[DW-2:0], div_ge};
			end else begin
				rem_q <= '0;
				unique case (djob_q)
					sdsu_pkg::JOB_MEAN: begin
						res_q[sdsu_pkg::STAT_MEAN] <= dq_q[63:0];
						dq_q <= DW'(t1_q);
						dd_q <= c1_q;
					end
					sdsu_pkg::JOB_LOW1: begin
						res_q[sdsu_pkg::STAT_LOW1] <= dq_q[63:0];
						dq_q <= DW'(t2_q);
						dd_q <= c2_q;
					end
					sdsu_pkg::JOB_LOW01: begin
						res_q[sdsu_pkg::STAT_LOW01] <= dq_q[63:0];
						dq_q <= num_q;
						dd_q <= count_q;
					end
					sdsu_pkg::JOB_VAR1: begin
						dd_q <= count_q;
					end
					default: begin
						res_q[sdsu_pkg::STAT_VAR] <= dq_q[63:0];
						sv_q <= dq_q[63:0];
						sr_q <= '0;
						sb_q <= 64'd1 << 62;
					end
				endcase
			end
		end
		if (state_q == sdsu_pkg::ST_SQRT) begin
			if (sb_q != '0) begin
				if (sq_ge) begin
					sv_q <= sv_q - sq_trial;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end else begin
				res_q[sdsu_pkg::STAT_STDDEV] <= sr_q;
			end
		end
		if (emit_go) begin
			stat_q.statistic   <= eidx_q;
			stat_q.value       <= res_q[eidx_q];
			stat_q.overflow    <= drop_q;
			stat_q.last_result <= emit_last;
		end
	end

	// The store never holds more than its capacity.
	`SDSU_ASSERT(a_count_bound, count_q <= CW'(CAPACITY))
	// The head cell holds a sample for every cycle of the scan.
	`SDSU_ASSERT_IMP(a_scan_head, state_q == sdsu_pkg::ST_SCAN, head_valid)
	// A sample is only dropped when the store was already full.
	`SDSU_ASSERT_IMP(a_drop_full, $rose(drop_q), $past(count_q) == CW'(CAPACITY))
	// Emitting the final result of a run returns the unit to loading.
	`SDSU_ASSERT_IMP(a_run_end, emit_go && emit_last, state_d == sdsu_pkg::ST_LOAD)
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam int CAP = 256;
	localparam longint CYCLE_LIMIT = 2000000;

	// Expected statistics are computed here from a sorted copy of the set.
	class stats_scoreboard;
		logic [31:0]     held[$];
		logic            dropped;
		sdsu_pkg::stat_t pending[$];
		int              errors;

		function new();
			dropped = 1'b0;
			errors = 0;
		endfunction

		function automatic logic [63:0] root64(logic [63:0] v);
			logic [63:0] r;
			logic [63:0] b;
			r = '0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function automatic logic [63:0] rank_pick(int n, int k);
			int rk;
			rk = (k * n + 99) / 100;
			if (rk < 1) rk = 1;
			if (rk > n) rk = n;
			return {32'd0, held[rk - 1]};
		endfunction

		function automatic logic [63:0] tail_avg(int n, int take);
			logic [63:0] s;
			s = 0;
			if (take < 1) take = 1;
			if (take > n) take = n;
			for (int i = n - take; i < n; i++) s += held[i];
			return s / take;
		endfunction

		function void push_stat(logic [3:0] st, logic [63:0] v);
			sdsu_pkg::stat_t e;
			e.statistic = st;
			e.value = v;
			e.overflow = dropped;
			e.last_result = 1'b0;
			pending.insert(pending.size(), e);
		endfunction

		// Notes one accepted load transaction.
		function void note_load(sdsu_pkg::load_t t);
			int n;
			logic [39:0] sum;
			logic [127:0] sq;
			logic [127:0] acc;
			if (t.has_sample) begin
				if (held.size() >= CAP) dropped = 1'b1;
				else begin
					int p;
					p = held.size();
					while (p > 0 && held[p - 1] > t.sample) p--;
					held.insert(p, t.sample);
				end
			end
			if (!t.last) return;
			n = held.size();
			push_stat(sdsu_pkg::STAT_COUNT, 64'(n));
			if (n > 0) begin
				sum = 0;
				sq = 0;
				foreach (held[i]) begin
					sum += held[i];
					sq += 128'(held[i]) * held[i];
				end
				push_stat(sdsu_pkg::STAT_MIN, 64'(held[0]));
				push_stat(sdsu_pkg::STAT_MAX, 64'(held[n - 1]));
				push_stat(sdsu_pkg::STAT_MEAN, 64'(sum / n));
				push_stat(sdsu_pkg::STAT_P10, rank_pick(n, 10));
				push_stat(sdsu_pkg::STAT_P10 + 4'd1, rank_pick(n, 50));
				push_stat(sdsu_pkg::STAT_P10 + 4'd2, rank_pick(n, 90));
				push_stat(sdsu_pkg::STAT_P10 + 4'd3, rank_pick(n, 95));
				push_stat(sdsu_pkg::STAT_P10 + 4'd4, rank_pick(n, 99));
				push_stat(sdsu_pkg::STAT_LOW1, tail_avg(n, (n + 99) / 100));
				push_stat(sdsu_pkg::STAT_LOW01, tail_avg(n, (n + 999) / 1000));
				acc = (sq * n - 128'(sum) * sum) / n / n;
				push_stat(sdsu_pkg::STAT_VAR, acc[63:0]);
				push_stat(sdsu_pkg::STAT_STDDEV, root64(acc[63:0]));
			end
			pending[pending.size() - 1].last_result = 1'b1;
			held.delete();
			dropped = 1'b0;
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		// Compares one accepted result with the oldest expectation.
		task check_stat(sdsu_pkg::stat_t got);
			sdsu_pkg::stat_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result stat %0d", got.statistic));
				return;
			end
			e = pending.pop_front();
			if (got.statistic !== e.statistic)
				report($sformatf("statistic %0d want %0d", got.statistic, e.statistic));
			if (got.value !== e.value)
				report($sformatf("stat %0d value %0h want %0h", e.statistic, got.value,
					e.value));
			if (got.overflow !== e.overflow)
				report($sformatf("stat %0d overflow %b", e.statistic, got.overflow));
			if (got.last_result !== e.last_result)
				report($sformatf("stat %0d last %b", e.statistic, got.last_result));
		endtask
	endclass

	logic            clk;
	logic            arst_n;
	logic            load_valid;
	logic            load_ready;
	sdsu_pkg::load_t load_data;
	logic            stat_valid;
	logic            stat_ready;
	sdsu_pkg::stat_t stat_data;
	longint          cycles;

	stats_scoreboard sb;

	sample_distribution_summary_unit #(.CAPACITY(CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.load_valid(load_valid), .load_ready(load_ready), .load_data(load_data),
		.stat_valid(stat_valid), .stat_ready(stat_ready), .stat_data(stat_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Sends one load transaction after a random gap; valid is held until it is taken.
	task automatic send_load(logic [31:0] s, logic h, logic l, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			load_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		load_valid <= 1'b1;
		load_data <= '{sample: s, has_sample: h, last: l};
		do @(posedge clk); while (!load_ready);
		sb.note_load('{sample: s, has_sample: h, last: l});
	endtask

	task automatic send_idle();
		load_valid <= 1'b0;
	endtask

	// Random sample content: mostly moderate frame times, sometimes extremes.
	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return $urandom_range(0, 3);
			default: return $urandom_range(32'h0008_0000, 32'h0030_0000);
		endcase
	endfunction

	task automatic send_set(int n, bit burst);
		for (int i = 0; i < n; i++) begin
			logic lst;
			lst = (i == n - 1) && ($urandom_range(0, 1) == 1);
			send_load(rand_sample(), 1'b1, lst, burst);
			if (lst) return;
		end
		send_load($urandom(), 1'b0, 1'b1, burst);
	endtask

	// The receiving side stalls a random number of cycles before each result.
	initial begin
		int wait_n;
		stat_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if (wait_n > 0) begin
				stat_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			stat_ready <= 1'b1;
			do @(posedge clk); while (!stat_valid);
			sb.check_stat(stat_data);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int sent;
		sb = new();
		arst_n = 1'b0;
		load_valid = 1'b0;
		load_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty set, single sample, extremes, sample on the closing item.
		send_load(32'hFFFF_FFFF, 1'b0, 1'b1);
		send_load(32'h0000_0000, 1'b1, 1'b1);
		send_load(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_load(32'hFFFF_FFFF, 1'b1, 1'b0);
		send_load(32'h0000_0000, 1'b1, 1'b0);
		send_load(32'h5555_AAAA, 1'b0, 1'b0);
		send_load(32'hAAAA_5555, 1'b1, 1'b1);
		send_load(32'h0010_0000, 1'b1, 1'b0);
		send_load(32'h0010_0000, 1'b1, 1'b0);
		send_load(32'h0000_0000, 1'b0, 1'b1);
		// Filling the store exactly, then a sample on the closing item: that sample
		// is dropped and overflow is raised.
		for (int i = 0; i < CAP; i++)
			send_load(rand_sample(), 1'b1, 1'b0, 1);
		send_load(32'h1234_5678, 1'b1, 1'b1);
		// An empty set afterwards carries no stale flag.
		send_load(32'd0, 1'b0, 1'b1);

		sent = 0;
		while (sent < 180) begin
			int n;
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(90, 140)
				: $urandom_range(0, 12);
			send_set(n, $urandom_range(0, 2) == 0);
			sent += n + 1;
		end
		send_idle();

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
